FILE: src/xsr_pkg.sv
// types and constants shared by the xorshift128 ranged random block
`timescale 1ns / 1ps
`default_nettype none

package xsr_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned CntWidth  = $clog2(WordWidth);

  localparam logic [WordWidth-1:0] SeedReset = 32'd123456789;
  localparam logic [WordWidth-1:0] InitY     = 32'd362436069;
  localparam logic [WordWidth-1:0] InitZ     = 32'd521288629;
  localparam logic [WordWidth-1:0] InitW     = 32'd88675123;

  localparam int unsigned ShiftXl = 11;
  localparam int unsigned ShiftWr = 19;
  localparam int unsigned ShiftTr = 8;

  typedef struct packed {
    logic [WordWidth-1:0] range_high;
    logic [WordWidth-1:0] range_low;
  } xsr_in_t;

  typedef struct packed {
    logic                 span_zero;
    logic [WordWidth-1:0] random_value;
  } xsr_out_t;

  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StRun,
    StHold
  } xsr_state_e;

endpackage

`default_nettype wire

FILE: src/xsr_gen.sv
// xorshift128 generator state, one step per request
`timescale 1ns / 1ps
`default_nettype none

module xsr_gen
  import xsr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 seed_we_i,
  input  wire logic [WordWidth-1:0] seed_i,
  output logic      [WordWidth-1:0] word_w_o
);

  logic [WordWidth-1:0] x_q, y_q, z_q, w_q;
  logic [WordWidth-1:0] t_d, w_d;

  always_comb begin
    t_d = x_q ^ (x_q << ShiftXl);
    w_d = w_q ^ (w_q >> ShiftWr) ^ t_d ^ (t_d >> ShiftTr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= SeedReset;
      y_q <= InitY;
      z_q <= InitZ;
      w_q <= InitW;
    end else if (step_i) begin
      x_q <= y_q;
      y_q <= z_q;
      z_q <= w_q;
      w_q <= w_d;
    end else if (seed_we_i) begin
      x_q <= seed_i;
    end
  end

  assign word_w_o = w_q;

endmodule

`default_nettype wire

FILE: src/xsr_rem.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module xsr_rem
  import xsr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WordWidth-1:0] dividend_i,
  input  wire logic [WordWidth-1:0] divisor_i,
  output logic                      done_o,
  output logic      [WordWidth-1:0] rem_o
);

  logic                 busy_q, done_q;
  logic [CntWidth-1:0]  cnt_q;
  logic [WordWidth-1:0] dvd_q, div_q, rem_q;
  logic [WordWidth:0]   trial, diff;
  logic [WordWidth-1:0] rem_d;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, dvd_q[WordWidth-1]};
    diff  = trial - {1'b0, div_q};
    rem_d = diff[WordWidth] ? trial[WordWidth-1:0] : diff[WordWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(WordWidth - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: src/xorshift128_ranged_random.sv
// from an accepted transaction to result valid: generator step, divisor load, one remainder
// iteration per dividend bit, completion, output load; a zero span skips the remainder
// one transaction is computed at a time; the remainder unit sets the pace
// the next transaction can be accepted the cycle after the result enters the output register
// reset (async, active low): generator words to their initial values, seed word
// 123456789, control idle, no result pending
`timescale 1ns / 1ps
`default_nettype none

module xorshift128_ranged_random
  import xsr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // seed write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [WordWidth-1:0] cfg_data_i,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire xsr_in_t              in_data_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output xsr_out_t                  out_data_o
);

  xsr_state_e state_q, state_d;

  logic                 in_fire;
  logic                 cfg_fire;
  logic                 rem_start;
  logic                 rem_done;
  logic [WordWidth-1:0] rem_val;
  logic [WordWidth-1:0] word_w;

  // request held while the remainder runs
  logic [WordWidth-1:0] low_q, span_q;
  logic                 zero_q;

  // output register parts the result from the request side
  logic     out_valid_q, out_valid_d;
  xsr_out_t out_data_q;
  logic     out_load;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  // seed writes only while idle, with no request offered and no result pending
  assign cfg_ready_o = (state_q == StIdle) && !out_valid_q && !in_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // generator steps once at request acceptance, new w is ready in the load state
  xsr_gen u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_fire),
    .seed_we_i (cfg_fire),
    .seed_i    (cfg_data_i),
    .word_w_o  (word_w)
  );

  xsr_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (word_w),
    .divisor_i  (span_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      low_q  <= in_data_i.range_low;
      span_q <= in_data_i.range_high - in_data_i.range_low;
      zero_q <= (in_data_i.range_high == in_data_i.range_low);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state: zero span skips the remainder and returns the lower bound
  always_comb begin
    state_d   = state_q;
    rem_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_fire) state_d = StLoad;
      end
      StLoad: begin
        if (zero_q) begin
          state_d = StHold;
        end else begin
          rem_start = 1'b1;
          state_d   = StRun;
        end
      end
      StRun: begin
        if (rem_done) state_d = StHold;
      end
      StHold: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result add wraps mod 2^32
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.span_zero    <= zero_q;
      out_data_q.random_value <= zero_q ? low_q : (rem_val + low_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: src/xsr_checker.sv
// port-level checker for the xorshift128 ranged random block, with bind
`timescale 1ns / 1ps
`default_nettype none

module xsr_checker
  import xsr_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 cfg_valid_i,
  input wire logic                 cfg_ready_o,
  input wire logic [WordWidth-1:0] cfg_data_i,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire xsr_in_t              in_data_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire xsr_out_t             out_data_o
);

  xsr_in_t              last_q;
  logic [WordWidth-1:0] span_c, off_c;
  logic                 cfg_seen;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) last_q <= in_data_i;
  end

  assign span_c   = last_q.range_high - last_q.range_low;
  assign off_c    = out_data_o.random_value - last_q.range_low;
  assign cfg_seen = cfg_valid_i && cfg_ready_o && (cfg_data_i == cfg_data_i);

  // one transaction in flight at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("result appeared in the cycle after acceptance");

  a_zero_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $rose(out_valid_o) && out_data_o.span_zero) |->
      (out_data_o.random_value == last_q.range_low && span_c == '0))
    else $error("zero span result is not the lower bound");

  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $rose(out_valid_o) && !out_data_o.span_zero) |->
      (span_c != '0 && off_c < span_c))
    else $error("result outside the requested range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && !cfg_seen) |=>
      (out_valid_o && $stable(out_data_o)))
    else $error("result changed while stalled");

endmodule

bind xorshift128_ranged_random xsr_checker u_xsr_checker (.*);

`default_nettype wire

FILE: verif/testbench.sv
// self-checking testbench for the xorshift128 ranged random block
`timescale 1ns / 1ps

// flow: reset, a table of directed requests under the reset seed, then three random
// phases, each after a seed write (zero, all ones, random) made while the block is idle.
// every accepted request is run through a local copy of the generator and the expected
// draw is queued; every accepted result is compared with the oldest queued draw.
// the sender works in bursts with random gaps; the receiver stalls on its own pattern
// and twice holds off for a long stretch so the block fills and blocks its input.
module testbench
  import xsr_pkg::*;
;

  localparam int unsigned StallLimit  = 2000;  // cycles with no transaction at all
  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
  localparam int unsigned SettleTicks = 50;    // settling margin at the end of the run

  // one row of the directed table; typed rows carry their expected result
  typedef struct {
    logic [WordWidth-1:0] low;
    logic [WordWidth-1:0] high;
    bit                   typed;
    logic [WordWidth-1:0] want_value;
    logic                 want_zero;
  } directed_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [WordWidth-1:0] cfg_data_i = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  xsr_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  xsr_out_t out_data_o;

  // local copy of the generator words and the seed
  logic [WordWidth-1:0] seed_reg = SeedReset;
  logic [WordWidth-1:0] gen_a    = SeedReset;
  logic [WordWidth-1:0] gen_b    = InitY;
  logic [WordWidth-1:0] gen_c    = InitZ;
  logic [WordWidth-1:0] gen_d    = InitW;

  xsr_out_t    pending_draws[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;

  // directed requests: zero spans, spans of one, wraps, bit-pattern extremes
  directed_row_t directed_rows [18] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},  // zero span at bottom
    '{32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b1},  // zero span at top
    '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},  // span one
    '{32'hffff_ffff, 32'h0000_0000, 1'b1, 32'hffff_ffff, 1'b0},  // span one, high wraps
    '{32'h0000_0000, 32'hffff_ffff, 1'b0, '0, 1'b0},             // largest plain span
    '{32'h0000_0001, 32'h0000_0000, 1'b0, '0, 1'b0},             // high below low, max span
    '{32'hffff_ffff, 32'hffff_fffe, 1'b0, '0, 1'b0},             // sum wraps past 2^32
    '{32'h8000_0000, 32'h0000_0000, 1'b0, '0, 1'b0},             // span 2^31
    '{32'h0000_0100, 32'h0000_0050, 1'b0, '0, 1'b0},             // high below low
    '{32'h0000_0000, 32'h0000_0002, 1'b0, '0, 1'b0},
    '{32'haaaa_aaaa, 32'h5555_5555, 1'b0, '0, 1'b0},
    '{32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0, 1'b0},
    '{32'h1234_5678, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b1},  // zero span mid range
    '{32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h7fff_ffff, 1'b0},  // span one across sign bit
    '{32'h0000_0000, 32'h0000_0010, 1'b0, '0, 1'b0},
    '{32'hffff_fff0, 32'h0000_0000, 1'b0, '0, 1'b0},             // span 16 wrapping
    '{32'hdead_beef, 32'hdead_bf53, 1'b0, '0, 1'b0},
    '{32'h0000_0000, 32'h8000_0000, 1'b0, '0, 1'b0}
  };

  xorshift128_ranged_random dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // advance the local generator one step and reduce the new word into the range
  function automatic xsr_out_t next_ranged_draw(xsr_in_t req);
    logic [WordWidth-1:0] mix;
    logic [WordWidth-1:0] span;
    xsr_out_t             draw;
    mix   = gen_a ^ (gen_a << ShiftXl);
    gen_a = gen_b;
    gen_b = gen_c;
    gen_c = gen_d;
    gen_d = gen_d ^ (gen_d >> ShiftWr) ^ mix ^ (mix >> ShiftTr);
    span  = req.range_high - req.range_low;
    if (span == '0) begin
      draw.random_value = req.range_low;
      draw.span_zero    = 1'b1;
    end else begin
      draw.random_value = (gen_d % span) + req.range_low;
      draw.span_zero    = 1'b0;
    end
    return draw;
  endfunction

  // random request, biased toward the interesting span classes
  function automatic xsr_in_t random_request();
    xsr_in_t     req;
    int unsigned kind;
    kind          = $urandom_range(0, 99);
    req.range_low = $urandom();
    if (kind < 30) begin
      req.range_high = req.range_low + $urandom_range(1, 64);  // small span
    end else if (kind < 40) begin
      req.range_high = req.range_low;  // zero span
    end else if (kind < 55) begin
      req.range_high = req.range_low + (32'd1 << $urandom_range(0, 31));  // power of two
    end else if (kind < 65) begin
      req.range_high = req.range_low - $urandom_range(1, 64);  // span near 2^32
    end else begin
      req.range_high = $urandom();
    end
    return req;
  endfunction

  task automatic report_mismatch(string what, logic [WordWidth-1:0] got,
                                 logic [WordWidth-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // offer one request, hold it until accepted, then queue its expected draw
  task automatic offer_request(xsr_in_t req, bit typed, xsr_out_t typed_draw);
    xsr_out_t predicted;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = next_ranged_draw(req);
    pending_draws.push_back(typed ? typed_draw : predicted);
  endtask

  // burst pacing for the sender: random burst lengths, random gaps between bursts
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // stop offering and wait until every expected draw has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
  endtask

  // seed write; the block also reloads its first generator word
  task automatic write_seed(logic [WordWidth-1:0] seed);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seed_reg = seed;
    gen_a    = seed_reg;
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) begin
      offer_request(random_request(), 1'b0, '0);
      pace_sender();
    end
  endtask

  // main sequence
  initial begin : main_flow
    xsr_in_t  req;
    xsr_out_t want;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset seed
    foreach (directed_rows[i]) begin
      req.range_low     = directed_rows[i].low;
      req.range_high    = directed_rows[i].high;
      want.random_value = directed_rows[i].want_value;
      want.span_zero    = directed_rows[i].want_zero;
      offer_request(req, directed_rows[i].typed, want);
      pace_sender();
    end
    drain_results();

    // random phases, each under a different seed
    write_seed(32'h0000_0000);
    run_random(175);
    drain_results();
    write_seed(32'hffff_ffff);
    run_random(175);
    drain_results();
    write_seed($urandom());
    run_random(180);
    drain_results();

    repeat (SettleTicks) @(posedge clk_i);
    if (pending_draws.size() != 0) begin
      report_mismatch("draws never returned", pending_draws.size(), '0);
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: ready pattern in segments of always-ready, coin-flip and mostly-stalled,
  // with two long hold-offs counted from reset release
  initial begin : result_receiver
    int unsigned rx_cycles;
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    rx_cycles = 0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (rx_cycles == 4000 || rx_cycles == 14000) begin
        out_ready_i <= 1'b0;
        hold_left = HoldCycles - 1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready_i <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  // result check against the oldest expected draw
  always @(posedge clk_i) begin : result_check
    xsr_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_draws.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.random_value, '0);
      end else begin
        want = pending_draws.pop_front();
        if (out_data_o.random_value !== want.random_value) begin
          report_mismatch("random_value", out_data_o.random_value, want.random_value);
        end
        if (out_data_o.span_zero !== want.span_zero) begin
          report_mismatch("span_zero", 32'(out_data_o.span_zero), 32'(want.span_zero));
        end
      end
    end
  end

  // watchdog: too long without any transaction on any channel ends the run
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
